// ===== rtl/bpea_pkg.sv =====
package bpea_pkg;

    // Largest block side accepted by default.
    localparam int unsigned BPEA_MAX_BLOCK_DIM = 64;

    // Field widths.
    localparam int unsigned IDX_W  = 13;
    localparam int unsigned REG_W  = 7;
    localparam int unsigned POS_W  = 20;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DIAG_BLOCK_COUNT = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE       = 2'd1;
    localparam logic [1:0] REG_LAST_BLOCK_SIZE  = 2'd2;

    // Reset values of the registers.
    localparam logic [REG_W-1:0] RST_DIAG_BLOCK_COUNT = 7'd1;
    localparam logic [REG_W-1:0] RST_BLOCK_SIZE       = 7'd1;
    localparam logic [REG_W-1:0] RST_LAST_BLOCK_SIZE  = 7'd0;

    // Configuration and the constants derived from it.
    typedef struct packed {
        logic [REG_W-1:0] k;       // number of regular diagonal blocks
        logic [REG_W-1:0] r;       // side of regular blocks
        logic [REG_W-1:0] s;       // side of final diagonal block
        logic             ok;      // geometry is usable
        logic [13:0]      kr;      // k*r
        logic [12:0]      tri_r;   // r*(r+1)/2
        logic [13:0]      r2;      // r*r
        logic [13:0]      sr;      // s*r
        logic [14:0]      dim;     // k*r + s
        logic [POS_W-1:0] tail;    // start of the off-diagonal blocks
        logic [POS_W-1:0] kmr2;    // (k-1)*r*r
    } cfg_t;

endpackage

// ===== rtl/bpea_cfg.sv =====
module bpea_cfg
    import bpea_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_DIM = BPEA_MAX_BLOCK_DIM
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [REG_W-1:0] k_reg, r_reg, s_reg;
    logic             wr_en;

    // Derived constants, first rank.
    logic [13:0] kr_reg, kr_next;
    logic [12:0] tri_r_reg, tri_r_next;
    logic [12:0] tri_s_reg, tri_s_next;
    logic [13:0] r2_reg, r2_next;
    logic [13:0] sr_reg, sr_next;
    logic [13:0] km1r_reg, km1r_next;
    logic [13:0] prod_r, prod_s;

    // Derived constants, second rank.
    logic [14:0]      dim_reg, dim_next;
    logic [POS_W-1:0] tail_reg, tail_next;
    logic [POS_W-1:0] kmr2_reg, kmr2_next;

    logic cfg_ok;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes; only the low seven bits of the data are kept.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= RST_DIAG_BLOCK_COUNT;
            r_reg <= RST_BLOCK_SIZE;
            s_reg <= RST_LAST_BLOCK_SIZE;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_DIAG_BLOCK_COUNT: k_reg <= pwdata[REG_W-1:0];
                REG_BLOCK_SIZE:       r_reg <= pwdata[REG_W-1:0];
                REG_LAST_BLOCK_SIZE:  s_reg <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (paddr[3:2])
            REG_DIAG_BLOCK_COUNT: prdata = {{(DATA_W-REG_W){1'b0}}, k_reg};
            REG_BLOCK_SIZE:       prdata = {{(DATA_W-REG_W){1'b0}}, r_reg};
            REG_LAST_BLOCK_SIZE:  prdata = {{(DATA_W-REG_W){1'b0}}, s_reg};
            default:              prdata = '0;
        endcase
    end

    // First rank: one small product each.
    always_comb begin
        prod_r     = {7'b0, r_reg} * ({7'b0, r_reg} + 14'd1);
        prod_s     = {7'b0, s_reg} * ({7'b0, s_reg} + 14'd1);
        kr_next    = {7'b0, k_reg} * {7'b0, r_reg};
        tri_r_next = prod_r[13:1];
        tri_s_next = prod_s[13:1];
        r2_next    = {7'b0, r_reg} * {7'b0, r_reg};
        sr_next    = {7'b0, s_reg} * {7'b0, r_reg};
        km1r_next  = {7'b0, k_reg - 7'd1} * {7'b0, r_reg};
    end

    // Second rank: sums and products built on first-rank values, taken modulo the position range.
    always_comb begin
        dim_next  = {1'b0, kr_reg} + {8'b0, s_reg};
        tail_next = {13'b0, k_reg} * {7'b0, tri_r_reg} + {7'b0, tri_s_reg};
        kmr2_next = {6'b0, km1r_reg} * {13'b0, r_reg};
    end

    always_ff @(posedge aclk) begin
        kr_reg    <= kr_next;
        tri_r_reg <= tri_r_next;
        tri_s_reg <= tri_s_next;
        r2_reg    <= r2_next;
        sr_reg    <= sr_next;
        km1r_reg  <= km1r_next;
        dim_reg   <= dim_next;
        tail_reg  <= tail_next;
        kmr2_reg  <= kmr2_next;
    end

    // A zero block size or an oversized register disables every lookup.
    assign cfg_ok = (r_reg != '0)
                 && (32'(k_reg) <= 32'(MAX_BLOCK_DIM))
                 && (32'(r_reg) <= 32'(MAX_BLOCK_DIM))
                 && (32'(s_reg) <= 32'(MAX_BLOCK_DIM));

    always_comb begin
        cfg.k     = k_reg;
        cfg.r     = r_reg;
        cfg.s     = s_reg;
        cfg.ok    = cfg_ok;
        cfg.kr    = kr_reg;
        cfg.tri_r = tri_r_reg;
        cfg.r2    = r2_reg;
        cfg.sr    = sr_reg;
        cfg.dim   = dim_reg;
        cfg.tail  = tail_reg;
        cfg.kmr2  = kmr2_reg;
    end

endmodule

// ===== rtl/block3_packed_element_address_unit.sv =====
// Channel   Direction  Fields (lowest bit first)
// s_        in         tdata: row_index[12:0], col_index[25:13]
// m_        out        tdata: position[19:0]; tuser: found
// APB       in/out     diag_block_count @0x0, block_size @0x4, last_block_size @0x8
//
// One request is taken every cycle unless a stall on m_tready reaches s_tready.
// The pipeline has eight register stages: input swap, four two-bit steps of the
// block-row division, block classification, multiplies, and the final sum.
// A stalled output holds; stages with empty slots still fill, so nothing is lost.
// Reset is synchronous on aresetn; it clears the valid bits and returns the
// configuration registers to their reset values.
module block3_packed_element_address_unit
    import bpea_pkg::*;
#(
    parameter int unsigned MAX_BLOCK_DIM = BPEA_MAX_BLOCK_DIM
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // row_index[12:0], col_index[25:13]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // position[19:0]
    output logic              m_tuser,   // found
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned NSTG = 8;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_DIAG,
        KIND_SUB,
        KIND_BOT
    } kind_t;

    typedef struct packed {
        logic [IDX_W-1:0] rem;
        logic [7:0]       q;
    } rq_t;

    typedef struct packed {
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        rq_t              di;
        rq_t              dj;
    } div_t;

    typedef struct packed {
        kind_t      kind;
        logic [6:0] ib;
        logic [6:0] jb;
        logic [6:0] ie;
        logic [6:0] je;
    } cls_t;

    cfg_t cfg;

    // Two bits of restoring division; the quotient never exceeds eight bits
    // for an index inside the matrix.
    function automatic rq_t div_step2(input rq_t x, input logic [6:0] d,
                                      input int unsigned b);
        logic [14:0] t;
        rq_t         y;
        y = x;
        for (int n = 1; n >= 0; n--) begin
            t = 15'(d) << (b + n);
            if ({2'b00, y.rem} >= t) begin
                y.rem        = y.rem - t[IDX_W-1:0];
                y.q[b + n]   = 1'b1;
            end
        end
        return y;
    endfunction

    bpea_cfg #(
        .MAX_BLOCK_DIM(MAX_BLOCK_DIM)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage valid bits and the ready chain; a stage moves when it is empty
    // or when the stage after it moves.
    logic [NSTG:1] v_reg;
    logic [NSTG:1] adv;

    always_comb begin
        adv[NSTG] = !v_reg[NSTG] || m_tready;
        for (int n = NSTG - 1; n >= 1; n--) begin
            adv[n] = !v_reg[n] || adv[n+1];
        end
    end

    assign s_tready = adv[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (adv[1]) begin
                v_reg[1] <= s_tvalid;
            end
            for (int n = 2; n <= NSTG; n++) begin
                if (adv[n]) begin
                    v_reg[n] <= v_reg[n-1];
                end
            end
        end
    end

    // Stage 1: fold into the lower triangle.
    logic [IDX_W-1:0] row_in, col_in;
    logic [IDX_W-1:0] p1_i_reg, p1_j_reg;

    assign row_in = s_tdata[12:0];
    assign col_in = s_tdata[25:13];

    always_ff @(posedge aclk) begin
        if (adv[1] && s_tvalid) begin
            p1_i_reg <= (row_in < col_in) ? col_in : row_in;
            p1_j_reg <= (row_in < col_in) ? row_in : col_in;
        end
    end

    // Stages 2 to 5: block row and column by two quotient bits per stage.
    div_t dv_reg [2:5];
    div_t dv_in  [2:5];

    always_comb begin
        dv_in[2].i      = p1_i_reg;
        dv_in[2].j      = p1_j_reg;
        dv_in[2].di.rem = p1_i_reg;
        dv_in[2].di.q   = '0;
        dv_in[2].dj.rem = p1_j_reg;
        dv_in[2].dj.q   = '0;
        for (int n = 3; n <= 5; n++) begin
            dv_in[n] = dv_reg[n-1];
        end
    end

    for (genvar g = 2; g <= 5; g++) begin : g_div
        always_ff @(posedge aclk) begin
            if (adv[g] && v_reg[g-1]) begin
                dv_reg[g].i  <= dv_in[g].i;
                dv_reg[g].j  <= dv_in[g].j;
                dv_reg[g].di <= div_step2(dv_in[g].di, cfg.r, 2 * (5 - g));
                dv_reg[g].dj <= div_step2(dv_in[g].dj, cfg.r, 2 * (5 - g));
            end
        end
    end

    // Stage 6: range check, clamp to the last block row and classify.
    cls_t        p6_reg, p6_next;
    logic        in_range, clamp_i, clamp_j;
    logic [13:0] i_off, j_off;

    always_comb begin
        in_range = cfg.ok && ({2'b00, dv_reg[5].i} < cfg.dim);
        clamp_i  = dv_reg[5].di.q > {1'b0, cfg.k};
        clamp_j  = dv_reg[5].dj.q > {1'b0, cfg.k};
        i_off    = {1'b0, dv_reg[5].i} - cfg.kr;
        j_off    = {1'b0, dv_reg[5].j} - cfg.kr;

        p6_next.ib = clamp_i ? cfg.k : dv_reg[5].di.q[6:0];
        p6_next.jb = clamp_j ? cfg.k : dv_reg[5].dj.q[6:0];
        p6_next.ie = clamp_i ? i_off[6:0] : dv_reg[5].di.rem[6:0];
        p6_next.je = clamp_j ? j_off[6:0] : dv_reg[5].dj.rem[6:0];

        if (!in_range) begin
            p6_next.kind = KIND_NONE;
        end else if (p6_next.ib == p6_next.jb) begin
            p6_next.kind = KIND_DIAG;
        end else if ((p6_next.ib < cfg.k)
                  && ({1'b0, p6_next.ib} == {1'b0, p6_next.jb} + 8'd1)) begin
            p6_next.kind = KIND_SUB;
        end else if (p6_next.ib == cfg.k) begin
            p6_next.kind = KIND_BOT;
        end else begin
            p6_next.kind = KIND_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[6] && v_reg[5]) begin
            p6_reg <= p6_next;
        end
    end

    // Stage 7: the two products and the block base plus column offset.
    logic [20:0]      m1_reg, m1_next;
    logic [14:0]      m2_reg, m2_next;
    logic [POS_W-1:0] base_reg, base_next;
    logic             diag_reg, found7_reg;
    logic [6:0]       op1;
    logic [13:0]      f1;
    logic [7:0]       f2;
    logic [POS_W-1:0] blk_base;

    always_comb begin
        case (p6_reg.kind)
            KIND_DIAG: begin
                op1      = p6_reg.ib;
                f1       = {1'b0, cfg.tri_r};
                f2       = {1'b0, p6_reg.ie} + 8'd1;
                blk_base = '0;
            end
            KIND_SUB: begin
                op1      = p6_reg.jb;
                f1       = cfg.r2;
                f2       = {1'b0, cfg.r};
                blk_base = cfg.tail;
            end
            KIND_BOT: begin
                op1      = p6_reg.jb;
                f1       = cfg.sr;
                f2       = {1'b0, cfg.r};
                blk_base = cfg.tail + cfg.kmr2;
            end
            default: begin
                op1      = '0;
                f1       = '0;
                f2       = '0;
                blk_base = '0;
            end
        endcase
        m1_next   = {14'b0, op1} * {7'b0, f1};
        m2_next   = {8'b0, p6_reg.ie} * {7'b0, f2};
        base_next = blk_base + {13'b0, p6_reg.je};
    end

    always_ff @(posedge aclk) begin
        if (adv[7] && v_reg[6]) begin
            m1_reg     <= m1_next;
            m2_reg     <= m2_next;
            base_reg   <= base_next;
            diag_reg   <= (p6_reg.kind == KIND_DIAG);
            found7_reg <= (p6_reg.kind != KIND_NONE);
        end
    end

    // Stage 8: final sum; the triangle term is halved for diagonal blocks.
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             found_reg;
    logic [POS_W-1:0] term2;

    always_comb begin
        term2    = diag_reg ? {6'b0, m2_reg[14:1]} : {5'b0, m2_reg};
        pos_next = base_reg + m1_reg[POS_W-1:0] + term2;
    end

    always_ff @(posedge aclk) begin
        if (adv[8] && v_reg[7]) begin
            pos_reg   <= found7_reg ? pos_next : '0;
            found_reg <= found7_reg;
        end
    end

    assign m_tvalid = v_reg[NSTG];
    assign m_tdata  = {4'b0, pos_reg};
    assign m_tuser  = found_reg;

endmodule
